@@ rtl/rtpg_pkg.sv @@
// Package with shared types, codes and G.711 expansion functions.
package rtpg_pkg;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_VERSION = 2'd2;
    localparam logic [1:0] ST_TYPE = 2'd3;
    localparam logic [1:0] CFG_PT = 2'd0;
    localparam logic [1:0] CFG_LAW = 2'd1;
    localparam logic [1:0] CFG_CLK = 2'd2;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        sample;
        logic        law;
        logic [1:0]  status;
        logic [15:0] seq;
        logic [31:0] ts;
    } t_job;

    function automatic logic [15:0] expand_mu(input logic [7:0] b);
        logic [7:0] u;
        logic [2:0] ex;
        logic [15:0] mag;
        u = ~b;
        ex = u[6:4];
        mag = (({9'd0, u[3:0], 3'd0} + 16'h84) << ex) - 16'h84;
        return u[7] ? (~mag + 16'd1) : mag;
    endfunction

    function automatic logic [15:0] expand_a(input logic [7:0] b);
        logic [7:0] v;
        logic [2:0] seg;
        logic [15:0] mag;
        v = b ^ 8'h55;
        seg = v[6:4];
        mag = {8'd0, v[3:0], 4'd0};
        if (seg == 3'd0) begin
            mag = mag + 16'd8;
        end else begin
            mag = (mag + 16'h108) << (seg - 3'd1);
        end
        return v[7] ? mag : (~mag + 16'd1);
    endfunction
endpackage

@@ rtl/rtpg_stream_if.sv @@
// Valid/ready channel interface with a generic payload.
interface rtpg_stream_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

@@ rtl/rtpg_front.sv @@
// Front end: header parsing, packet classification and job issue.
module rtpg_front import rtpg_pkg::*; #(
    parameter int MAX_PACKET_BYTES = 2048
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic [6:0] i_pt,
    input  logic       i_law,
    input  logic       i_full,
    output logic       o_ready,
    output logic       o_push,
    output t_job       o_job
);
    logic [15:0] r_pos;
    logic [6:0]  r_hlen;
    logic        r_vbad, r_tbad;
    logic [15:0] r_seq;
    logic [31:0] r_ts;
    logic        vbad, tbad, smp, acc;
    logic [6:0]  hlen;
    logic [15:0] cnt;
    logic [1:0]  st;

    assign o_ready = !i_full;
    assign acc = i_valid && o_ready;
    always_comb begin
        vbad = r_vbad;
        tbad = r_tbad;
        hlen = r_hlen;
        if (r_pos == 16'd0) begin
            vbad = i_byte[7:6] != 2'd2;
            hlen = 7'd12 + {1'b0, i_byte[3:0], 2'd0};
        end else if (r_pos == 16'd1) begin
            tbad = i_byte[6:0] != i_pt;
        end
        smp = !vbad && !tbad && r_pos >= {9'd0, hlen}
              && 32'(r_pos) < 32'(MAX_PACKET_BYTES);
        cnt = (r_pos != 16'hFFFF) ? r_pos + 16'd1 : r_pos;
        if (cnt < 16'd12) st = ST_SHORT;
        else if (vbad) st = ST_VERSION;
        else if (cnt < {9'd0, hlen}) st = ST_SHORT;
        else if (tbad) st = ST_TYPE;
        else st = ST_OK;
    end
    assign o_push = acc && (smp || i_last);
    assign o_job = '{data: i_byte, last: i_last, sample: smp, law: i_law, status: st,
                     seq: r_seq, ts: r_ts};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_hlen <= 7'd12; r_vbad <= 1'b0; r_tbad <= 1'b0;
            r_seq <= '0; r_ts <= '0;
        end else if (acc) begin
            if (r_pos == 16'd2 || r_pos == 16'd3) r_seq <= {r_seq[7:0], i_byte};
            if (r_pos >= 16'd4 && r_pos <= 16'd7) r_ts <= {r_ts[23:0], i_byte};
            if (i_last) begin
                r_pos <= '0; r_hlen <= 7'd12; r_vbad <= 1'b0; r_tbad <= 1'b0;
            end else begin
                r_pos <= cnt; r_hlen <= hlen; r_vbad <= vbad; r_tbad <= tbad;
            end
        end
    end
endmodule

@@ rtl/rtpg_divider.sv @@
// Restoring divider, one quotient bit per cycle.
module rtpg_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_busy,
    output logic [63:0] o_quot
);
    logic [63:0] r_q;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [6:0]  r_cnt;
    logic [32:0] n_rem;
    logic [32:0] trial;

    assign o_busy = r_cnt != 7'd0;
    assign o_quot = r_q;
    always_comb begin
        n_rem = {r_rem[31:0], r_q[63]};
        trial = n_rem - {1'b0, r_den};
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_q <= i_num; r_rem <= '0; r_den <= i_den; r_cnt <= 7'd64;
        end else if (o_busy) begin
            r_cnt <= r_cnt - 7'd1;
            if (!trial[32]) begin
                r_rem <= trial; r_q <= {r_q[62:0], 1'b1};
            end else begin
                r_rem <= n_rem; r_q <= {r_q[62:0], 1'b0};
            end
        end
    end
endmodule

@@ rtl/rtpg_back.sv @@
// Back end: sample expansion, statistics update and result register.
module rtpg_back import rtpg_pkg::*; #(
    parameter int JITTER_FRACTION_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_job        i_job,
    input  logic [17:0] i_clk_rate,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_pcm,
    output logic        o_sample_valid,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [31:0] o_recv,
    output logic [31:0] o_lost,
    output logic [14:0] o_pct,
    output logic [31:0] o_jit
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_JDIV = 5'b00010, S_JMUL = 5'b00100,
        S_PDIV = 5'b01000, S_OUT = 5'b10000
    } t_state;
    t_state r_state;
    logic        r_prev_ok;
    logic [15:0] r_pseq;
    logic [31:0] r_pts, r_acc, r_lost, r_jit, r_diff;
    logic [1:0]  r_st;
    logic        r_upd;
    logic        dv_start, dv_busy;
    logic [63:0] dv_num, dv_q;
    logic [31:0] dv_den, mag;
    logic [63:0] nj;
    logic [31:0] total;
    logic [15:0] gap;

    rtpg_divider u_div (
        .i_clk, .i_rst_n, .i_start(dv_start), .i_num(dv_num), .i_den(dv_den),
        .o_busy(dv_busy), .o_quot(dv_q)
    );

    assign total = r_acc + r_lost;
    assign mag = r_diff[31] ? (~r_diff + 32'd1) : r_diff;
    assign nj = 64'(r_jit) * 64'd15 + dv_q;
    assign gap = i_job.seq - (r_pseq + 16'd1);
    assign o_pop = !i_empty && r_state == S_IDLE && (!o_valid || i_ready);

    always_comb begin
        dv_start = 1'b0;
        dv_num = 64'(mag) * 64'(1000 * (2 ** JITTER_FRACTION_BITS));
        dv_den = (i_clk_rate == 18'd0) ? 32'd1 : 32'(i_clk_rate);
        case (r_state)
            S_JMUL: begin
                dv_start = 1'b1;
            end
            S_PDIV: begin
                dv_num = 64'(r_lost) * 64'd25600;
                dv_den = total;
                dv_start = !r_upd;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; o_valid <= 1'b0; r_prev_ok <= 1'b0;
            r_pseq <= '0; r_pts <= '0; r_acc <= '0; r_lost <= '0; r_jit <= '0;
            r_upd <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        o_pcm <= i_job.sample ? (i_job.law ? expand_a(i_job.data)
                                                           : expand_mu(i_job.data)) : 16'd0;
                        o_sample_valid <= i_job.sample;
                        o_done <= i_job.last;
                        r_st <= i_job.status;
                        o_status <= '0; o_recv <= '0; o_lost <= '0; o_pct <= '0; o_jit <= '0;
                        o_valid <= !i_job.last;
                        if (!i_job.last) begin
                        end else if (i_job.status == ST_OK) begin
                            r_acc <= r_acc + 32'd1;
                            r_pseq <= i_job.seq; r_pts <= i_job.ts; r_prev_ok <= 1'b1;
                            if (r_prev_ok) begin
                                r_lost <= r_lost + {16'd0, gap};
                                r_diff <= i_job.ts - r_pts;
                                r_state <= S_JMUL;
                            end else begin
                                r_state <= S_PDIV; r_upd <= 1'b0;
                            end
                        end else begin
                            r_state <= S_PDIV; r_upd <= 1'b0;
                        end
                    end else if (i_ready) begin
                        o_valid <= 1'b0;
                    end
                end
                S_JMUL: r_state <= S_JDIV;
                S_JDIV: if (!dv_busy) begin
                    r_jit <= (nj[63:4] > 60'hFFFFFFFF) ? 32'hFFFFFFFF : nj[35:4];
                    r_state <= S_PDIV; r_upd <= 1'b0;
                end
                S_PDIV: begin
                    if (total == 32'd0) begin
                        o_pct <= '0; r_state <= S_OUT;
                    end else if (!r_upd) begin
                        r_upd <= 1'b1;
                    end else if (!dv_busy) begin
                        o_pct <= (dv_q > 64'd25600) ? 15'd25600 : dv_q[14:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    o_status <= r_st; o_recv <= r_acc; o_lost <= r_lost; o_jit <= r_jit;
                    o_valid <= 1'b1; r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ rtl/rtp_g711_depacketizer.sv @@
// Top level: RTP G.711 depacketizer with stream statistics.
// A sample result passes through the job queue and the output register after its byte is accepted; a final
// result also waits for up to two 64-step serial divisions (jitter, loss percent).
// Throughput: one byte per cycle while the 4-entry job queue has room; stalls during statistics.
// Synchronous active-low reset clears all counters, statistics and the queue;
// configuration returns to payload type 0, mu-law and 8000 Hz.
module rtp_g711_depacketizer import rtpg_pkg::*; #(
    parameter int MAX_PACKET_BYTES = 2048,
    parameter int JITTER_FRACTION_BITS = 8
) (
    input logic      i_clk,
    input logic      i_rst_n,
    rtpg_stream_if.sink   s_in,
    rtpg_stream_if.sink   s_cfg,
    rtpg_stream_if.source m_out
);
    localparam int QD = 4;
    logic [6:0]  r_pt;
    logic        r_law;
    logic [17:0] r_rate;
    t_job        q_mem [QD];
    logic [1:0]  r_wp, r_rp;
    logic [2:0]  r_cnt;
    logic        push, pop, full;
    t_job        job;
    logic [15:0] pcm;
    logic        sv, dn;
    logic [1:0]  st;
    logic [31:0] rc, lc, jt;
    logic [14:0] pc;

    assign s_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pt <= '0; r_law <= 1'b0; r_rate <= 18'd8000;
        end else if (s_cfg.valid) begin
            case (s_cfg.data[33:32])
                CFG_PT: r_pt <= s_cfg.data[6:0];
                CFG_LAW: r_law <= s_cfg.data[0];
                CFG_CLK: r_rate <= s_cfg.data[17:0];
                default: begin
                end
            endcase
        end
    end

    assign full = r_cnt == 3'(QD);
    rtpg_front #(.MAX_PACKET_BYTES(MAX_PACKET_BYTES)) u_front (
        .i_clk, .i_rst_n, .i_valid(s_in.valid), .i_byte(s_in.data[7:0]),
        .i_last(s_in.data[8]), .i_pt(r_pt), .i_law(r_law), .i_full(full),
        .o_ready(s_in.ready), .o_push(push), .o_job(job)
    );

    always_ff @(posedge i_clk) begin
        if (push) q_mem[r_wp] <= job;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 2'd1;
            if (pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(push) - 3'(pop);
        end
    end

    rtpg_back #(.JITTER_FRACTION_BITS(JITTER_FRACTION_BITS)) u_back (
        .i_clk, .i_rst_n, .i_empty(r_cnt == 3'd0), .i_job(q_mem[r_rp]),
        .i_clk_rate(r_rate), .o_pop(pop),
        .o_valid(m_out.valid), .i_ready(m_out.ready), .o_pcm(pcm),
        .o_sample_valid(sv), .o_done(dn), .o_status(st), .o_recv(rc),
        .o_lost(lc), .o_pct(pc), .o_jit(jt)
    );
    assign m_out.data = {jt, pc, lc, rc, st, dn, sv, pcm};
endmodule

@@ tb/tb_rtp_g711_depacketizer.sv @@
// Testbench for rtp_g711_depacketizer: random RTP streams checked against a packet predictor.
`timescale 1ns / 1ps
module tb_rtp_g711_depacketizer import rtpg_pkg::*; ();

    typedef struct packed {
        logic       eop;
        logic [7:0] pkt_byte;
    } t_byte_in;

    typedef struct packed {
        logic [1:0]  index;
        logic [31:0] value;
    } t_cfg_wr;

    typedef struct packed {
        logic [31:0] jitter;
        logic [14:0] loss_pct;
        logic [31:0] lost;
        logic [31:0] rx_count;
        logic [1:0]  status;
        logic        done;
        logic        smp_valid;
        logic [15:0] pcm;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rtpg_stream_if #(.W($bits(t_byte_in))) s_in();
    rtpg_stream_if #(.W($bits(t_cfg_wr))) s_cfg();
    rtpg_stream_if #(.W($bits(t_result))) m_out();

    rtp_g711_depacketizer dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_in(s_in.sink),
        .s_cfg(s_cfg.sink),
        .m_out(m_out.source)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_byte_in pending_bytes[$];
    t_result  expected_results[$];
    int       fail_count = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;

    // Predictor copy of the configuration and stream state.
    logic [6:0]  pt_want = 7'd0;
    logic        law_a = 1'b0;
    logic [17:0] clk_rate = 18'd8000;
    int unsigned pos = 0;
    int unsigned hdr_len = 12;
    logic        ver_bad = 1'b0;
    logic        pt_bad = 1'b0;
    logic [15:0] seq_cap = 16'd0;
    logic [31:0] ts_cap = 32'd0;
    logic        seen_prev = 1'b0;
    logic [15:0] prev_seq = 16'd0;
    logic [31:0] prev_ts = 32'd0;
    logic [31:0] rx_total = 32'd0;
    logic [31:0] lost_total = 32'd0;
    logic [31:0] jitter_avg = 32'd0;

    function automatic logic [15:0] mu_to_linear(input logic [7:0] b);
        logic [7:0]  u;
        logic [31:0] mag;
        u = ~b;
        mag = ((({28'd0, u[3:0]} << 3) + 32'h84) << u[6:4]) - 32'h84;
        return u[7] ? 16'(-mag) : mag[15:0];
    endfunction

    function automatic logic [15:0] a_law_to_pcm(input logic [7:0] b);
        logic [7:0]  v;
        logic [31:0] mag;
        v = b ^ 8'h55;
        mag = {28'd0, v[3:0]} << 4;
        if (v[6:4] == 3'd0) begin
            mag = mag + 32'd8;
        end else begin
            mag = (mag + 32'h108) << (v[6:4] - 3'd1);
        end
        return v[7] ? mag[15:0] : 16'(-mag);
    endfunction

    task automatic close_packet_stats();
        logic [15:0] gap;
        logic [31:0] diff;
        logic [63:0] delta_mag;
        logic [63:0] ms;
        logic [63:0] avg;
        rx_total = rx_total + 32'd1;
        if (seen_prev) begin
            gap = seq_cap - (prev_seq + 16'd1);
            diff = ts_cap - prev_ts;
            delta_mag = diff[31] ? {32'd0, (~diff) + 32'd1} : {32'd0, diff};
            lost_total = lost_total + {16'd0, gap};
            ms = (delta_mag * 64'd256000) / ((clk_rate == 18'd0) ? 64'd1 : {46'd0, clk_rate});
            avg = (64'd15 * {32'd0, jitter_avg} + ms) >> 4;
            jitter_avg = (avg > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : avg[31:0];
        end
        prev_seq = seq_cap;
        prev_ts = ts_cap;
        seen_prev = 1'b1;
    endtask

    task automatic predict_byte(input t_byte_in it);
        t_result     r;
        int unsigned idx;
        int unsigned cnt;
        logic        smp;
        logic [31:0] tot;
        logic [63:0] pct;
        idx = pos;
        smp = 1'b0;
        r = '0;
        if (idx == 0) begin
            ver_bad = it.pkt_byte[7:6] != 2'd2;
            hdr_len = 12 + 4 * it.pkt_byte[3:0];
        end else if (idx == 1) begin
            pt_bad = it.pkt_byte[6:0] != pt_want;
        end else if (idx == 2 || idx == 3) begin
            seq_cap = {seq_cap[7:0], it.pkt_byte};
        end else if (idx >= 4 && idx <= 7) begin
            ts_cap = {ts_cap[23:0], it.pkt_byte};
        end
        if (!ver_bad && !pt_bad && idx >= hdr_len && idx < 2048) begin
            smp = 1'b1;
            r.pcm = law_a ? a_law_to_pcm(it.pkt_byte) : mu_to_linear(it.pkt_byte);
        end
        cnt = (idx < 65535) ? idx + 1 : 65535;
        pos = cnt;
        r.smp_valid = smp;
        if (it.eop) begin
            if (cnt < 12) r.status = ST_SHORT;
            else if (ver_bad) r.status = ST_VERSION;
            else if (cnt < hdr_len) r.status = ST_SHORT;
            else if (pt_bad) r.status = ST_TYPE;
            else r.status = ST_OK;
            if (r.status == ST_OK) close_packet_stats();
            tot = rx_total + lost_total;
            pct = 64'd0;
            if (tot != 32'd0) begin
                pct = ({32'd0, lost_total} * 64'd25600) / {32'd0, tot};
                if (pct > 64'd25600) pct = 64'd25600;
            end
            r.done = 1'b1;
            r.rx_count = rx_total;
            r.lost = lost_total;
            r.loss_pct = pct[14:0];
            r.jitter = jitter_avg;
            pos = 0;
            hdr_len = 12;
            ver_bad = 1'b0;
            pt_bad = 1'b0;
        end
        if (smp || it.eop) expected_results.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Byte driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_in.valid <= 1'b0;
        end else begin
            if (s_in.valid && s_in.ready) predict_byte(t_byte_in'(s_in.data));
            if (!s_in.valid || s_in.ready) begin
                if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_in.valid <= 1'b1;
                    s_in.data <= pending_bytes.pop_front();
                end else begin
                    s_in.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            m_out.ready <= 1'b0;
        end else begin
            if (m_out.valid && m_out.ready) begin
                got = t_result'(m_out.data);
                if (expected_results.size() == 0) begin
                    $error("result with no expectation waiting: %h", got);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("pcm_sample", want.pcm, got.pcm);
                    check_field("sample_valid", want.smp_valid, got.smp_valid);
                    check_field("packet_done", want.done, got.done);
                    check_field("status", want.status, got.status);
                    check_field("received_count", want.rx_count, got.rx_count);
                    check_field("lost_count", want.lost, got.lost);
                    check_field("loss_percent_q8", want.loss_pct, got.loss_pct);
                    check_field("jitter_ms_q8", want.jitter, got.jitter);
                end
            end
            m_out.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [17:0] val);
        t_cfg_wr w;
        w.index = idx;
        w.value = {14'd0, val};
        @(posedge i_clk);
        s_cfg.valid <= 1'b1;
        s_cfg.data <= w;
        do @(posedge i_clk); while (!s_cfg.ready);
        s_cfg.valid <= 1'b0;
        if (idx == CFG_PT) pt_want = val[6:0];
        else if (idx == CFG_LAW) law_a = val[0];
        else if (idx == CFG_CLK) clk_rate = val;
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() > 0 || s_in.valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // cut_len < 0 keeps the whole packet; otherwise the packet is truncated to cut_len bytes.
    task automatic push_packet(input logic [1:0] ver, input logic [3:0] cc, input logic [6:0] pt,
                               input logic [15:0] seq, input logic [31:0] ts,
                               input int pay_len, input int cut_len);
        logic [7:0] bytes[$];
        t_byte_in   it;
        int         n;
        bytes.push_back({ver, 2'($urandom_range(3)), cc});
        bytes.push_back({1'($urandom_range(1)), pt});
        bytes.push_back(seq[15:8]);
        bytes.push_back(seq[7:0]);
        for (int k = 3; k >= 0; k--) bytes.push_back(ts[8*k +: 8]);
        for (int k = 0; k < 4 + 4 * cc + pay_len; k++) bytes.push_back(8'($urandom));
        n = (cut_len < 0) ? bytes.size() : cut_len;
        for (int k = 0; k < n; k++) begin
            it.pkt_byte = bytes[k];
            it.eop = (k == n - 1);
            pending_bytes.push_back(it);
        end
    endtask

    logic [15:0] seq_gen;
    logic [31:0] ts_gen;

    task automatic random_stream(input int n_bytes);
        int          start;
        int          kind;
        int          plen;
        logic [3:0]  cc;
        start = pending_bytes.size();
        while (pending_bytes.size() - start < n_bytes) begin
            kind = $urandom_range(99);
            plen = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(12);
            cc = ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1));
            seq_gen = seq_gen + (($urandom_range(4) == 0) ? 16'($urandom) : 16'd1);
            ts_gen = ts_gen + (($urandom_range(5) == 0) ? 32'($urandom) : 32'($urandom_range(400)));
            if (kind < 75) begin
                push_packet(2'd2, cc, pt_want, seq_gen, ts_gen, plen, -1);
            end else if (kind < 80) begin
                push_packet(2'd2, cc, pt_want, seq_gen, ts_gen, plen, 1 + $urandom_range(10));
            end else if (kind < 85) begin
                push_packet(2'($urandom_range(1) ? 3 : $urandom_range(1)), cc, pt_want,
                            seq_gen, ts_gen, plen, -1);
            end else if (kind < 90) begin
                push_packet(2'd2, cc, pt_want + 7'd1 + 7'($urandom_range(125)), seq_gen,
                            ts_gen, plen, -1);
            end else if (kind < 95) begin
                push_packet(2'd2, 4'd1 + 4'($urandom_range(14)), pt_want, seq_gen, ts_gen,
                            0, 12 + $urandom_range(3));
            end else begin
                push_packet(2'($urandom), 4'($urandom), 7'($urandom), 16'($urandom),
                            32'($urandom), plen, -1);
            end
        end
    endtask

    task automatic run_phase(input int idle, input int stall, input int n_bytes);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        random_stream(n_bytes);
        wait_drained();
    endtask

    initial begin
        s_in.valid = 1'b0;
        s_in.data = '0;
        s_cfg.valid = 1'b0;
        s_cfg.data = '0;
        m_out.ready = 1'b0;
        seq_gen = 16'($urandom);
        ts_gen = 32'($urandom);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);

        // Directed packets at reset configuration.
        push_packet(2'd2, 4'd0, 7'd0, 16'hFFFF, 32'h0000_0000, 4, -1);
        push_packet(2'd2, 4'd0, 7'd0, 16'h0000, 32'h8000_0000, 2, -1);
        push_packet(2'd2, 4'd0, 7'd0, 16'h0005, 32'h0000_0000, 0, -1);
        push_packet(2'd2, 4'd15, 7'd0, 16'h0006, 32'hFFFF_FF00, 1, -1);
        push_packet(2'd2, 4'd3, 7'd0, 16'h0007, 32'h0, 0, 20);
        push_packet(2'd2, 4'd0, 7'd0, 16'h0008, 32'h0, 0, 1);
        push_packet(2'd2, 4'd0, 7'd0, 16'h0008, 32'h0, 0, 11);
        push_packet(2'd0, 4'd0, 7'd0, 16'h0009, 32'h0, 3, -1);
        push_packet(2'd1, 4'd0, 7'd0, 16'h0009, 32'h0, 0, 5);
        push_packet(2'd3, 4'd0, 7'd0, 16'h0009, 32'h0, 0, -1);
        push_packet(2'd2, 4'd0, 7'd127, 16'h0009, 32'h0, 3, -1);
        wait_drained();
        run_phase(0, 0, 110);

        write_reg(CFG_PT, 18'd127);
        write_reg(CFG_LAW, 18'd1);
        write_reg(CFG_CLK, 18'd192000);
        push_packet(2'd2, 4'd0, 7'd127, 16'h1000, 32'h0, 64, -1);
        run_phase(77, 0, 110);

        write_reg(CFG_PT, 18'($urandom_range(127)));
        write_reg(CFG_LAW, 18'd0);
        write_reg(CFG_CLK, 18'd1);
        push_packet(2'd2, 4'd0, pt_want, 16'h2000, 32'h0, 64, -1);
        push_packet(2'd2, 4'd0, pt_want, 16'h2001, 32'h8000_0000, 1, -1);
        run_phase(0, 77, 110);

        write_reg(CFG_PT, 18'd96);
        write_reg(CFG_LAW, 18'($urandom_range(1)));
        write_reg(CFG_CLK, 18'($urandom_range(262143)));
        run_phase(21, 21, 110);

        write_reg(CFG_CLK, 18'd0);
        run_phase(0, 0, 50);

        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("tb_rtp_g711_depacketizer passed");
        end else begin
            $display("tb_rtp_g711_depacketizer failed");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("tb_rtp_g711_depacketizer failed");
        $finish;
    end
endmodule
